/* hdl/tcdt_pkg.sv */
// tcdt_pkg: shared types and constants for the triangle coverage and depth test
// item and result payloads, queue entry layout, back-end state encoding
// no dependencies
package tcdt_pkg;

	localparam int SCREEN_WIDTH    = 640;
	localparam int SCREEN_HEIGHT   = 480;
	localparam int COORD_FRAC_BITS = 4;
	localparam int DEPTH_BITS      = 24;
	localparam int FIFO_DEPTH      = 4;
	localparam int FIFO_AW         = 2;
	localparam int CW              = 19;
	localparam int PW              = 2 * CW;
	localparam int EW              = PW + 1;
	localparam int MW              = PW;
	localparam int SW              = MW + 2;
	localparam int WW              = 16;
	localparam int ACCW            = 42;

	typedef struct packed {
		logic signed [15:0]           vertex_a_x;
		logic signed [15:0]           vertex_a_y;
		logic signed [23:0]           vertex_a_depth;
		logic signed [15:0]           vertex_b_x;
		logic signed [15:0]           vertex_b_y;
		logic signed [23:0]           vertex_b_depth;
		logic signed [15:0]           vertex_c_x;
		logic signed [15:0]           vertex_c_y;
		logic signed [23:0]           vertex_c_depth;
		logic [9:0]                   pixel_x;
		logic [8:0]                   pixel_y;
	} item_t;

	typedef struct packed {
		logic                         covered;
		logic                         depth_written;
		logic signed [DEPTH_BITS-1:0] frag_depth;
		logic [WW-1:0]                weight_a;
		logic [WW-1:0]                weight_b;
		logic [WW-1:0]                weight_c;
		logic [9:0]                   out_pixel_x;
		logic [8:0]                   out_pixel_y;
	} result_t;

	typedef struct packed {
		logic                         covered;
		logic                         onscreen;
		logic [MW-1:0]                m_ab;
		logic [MW-1:0]                m_bc;
		logic [MW-1:0]                m_ca;
		logic signed [23:0]           za;
		logic signed [23:0]           zb;
		logic signed [23:0]           zc;
		logic [9:0]                   px;
		logic [8:0]                   py;
	} entry_t;

	typedef struct packed {
		logic                         push;
		logic                         full;
	} queue_ctl_t;

	typedef enum logic [2:0] {
		B_CLR,
		B_IDLE,
		B_DIV,
		B_MUL,
		B_RD,
		B_CMP,
		B_OUT
	} back_state_t;

endpackage

/* hdl/tcdt_front.sv */
// tcdt_front: two-stage edge function front end, products then sign classification
// depends on tcdt_pkg
module tcdt_front #(
	parameter int SCREEN_WIDTH  = tcdt_pkg::SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = tcdt_pkg::SCREEN_HEIGHT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  tcdt_pkg::item_t     item,
	input  logic                clearing,
	input  logic                queue_full,
	output logic                push,
	output tcdt_pkg::entry_t    entry
);

	logic signed [tcdt_pkg::CW-1:0] ax, ay, bx, by, cx, cy, pxc, pyc;
	logic signed [tcdt_pkg::PW-1:0] p0, p1, p2, p3, p4, p5;
	logic signed [tcdt_pkg::PW-1:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	tcdt_pkg::item_t                item_s1;
	logic                           v_s1, v_s2;
	logic signed [tcdt_pkg::EW-1:0] e_ab, e_bc, e_ca;
	tcdt_pkg::entry_t               entry_s2;
	logic                           s2_free;

	always_comb begin
		ax  = $signed({item.vertex_a_x, 1'b0});
		ay  = $signed({item.vertex_a_y, 1'b0});
		bx  = $signed({item.vertex_b_x, 1'b0});
		by  = $signed({item.vertex_b_y, 1'b0});
		cx  = $signed({item.vertex_c_x, 1'b0});
		cy  = $signed({item.vertex_c_y, 1'b0});
		pxc = $signed(tcdt_pkg::CW'({item.pixel_x, 1'b1}) << tcdt_pkg::COORD_FRAC_BITS);
		pyc = $signed(tcdt_pkg::CW'({item.pixel_y, 1'b1}) << tcdt_pkg::COORD_FRAC_BITS);
		p0  = (bx - ax) * (pyc - ay);
		p1  = (by - ay) * (pxc - ax);
		p2  = (cx - bx) * (pyc - by);
		p3  = (cy - by) * (pxc - bx);
		p4  = (ax - cx) * (pyc - cy);
		p5  = (ay - cy) * (pxc - cx);
	end

	assign push       = v_s2 && !queue_full;
	assign s2_free    = !v_s2 || push;
	assign item_ready = (!v_s1 || s2_free) && !clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (item_ready)
				v_s1 <= item_valid;
			if (s2_free)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			p0_s1   <= p0;
			p1_s1   <= p1;
			p2_s1   <= p2;
			p3_s1   <= p3;
			p4_s1   <= p4;
			p5_s1   <= p5;
			item_s1 <= item;
		end
	end

	always_comb begin
		e_ab = p0_s1 - p1_s1;
		e_bc = p2_s1 - p3_s1;
		e_ca = p4_s1 - p5_s1;
	end

	always_ff @(posedge clk) begin
		if (s2_free && v_s1) begin
			entry_s2.covered  <= (e_ab > 0 && e_bc > 0 && e_ca > 0) ||
				(e_ab < 0 && e_bc < 0 && e_ca < 0);
			entry_s2.onscreen <= (32'(item_s1.pixel_x) < 32'(SCREEN_WIDTH)) &&
				(32'(item_s1.pixel_y) < 32'(SCREEN_HEIGHT));
			entry_s2.m_ab <= e_ab[tcdt_pkg::EW-1] ? tcdt_pkg::MW'(-e_ab) : tcdt_pkg::MW'(e_ab);
			entry_s2.m_bc <= e_bc[tcdt_pkg::EW-1] ? tcdt_pkg::MW'(-e_bc) : tcdt_pkg::MW'(e_bc);
			entry_s2.m_ca <= e_ca[tcdt_pkg::EW-1] ? tcdt_pkg::MW'(-e_ca) : tcdt_pkg::MW'(e_ca);
			entry_s2.za   <= item_s1.vertex_a_depth;
			entry_s2.zb   <= item_s1.vertex_b_depth;
			entry_s2.zc   <= item_s1.vertex_c_depth;
			entry_s2.px   <= item_s1.pixel_x;
			entry_s2.py   <= item_s1.pixel_y;
		end
	end

	assign entry = entry_s2;

endmodule

/* hdl/tcdt_fifo.sv */
// tcdt_fifo: short queue of classified fragments between front and back end
// depends on tcdt_pkg
module tcdt_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcdt_pkg::queue_ctl_t wr,
	input  tcdt_pkg::entry_t     wr_entry,
	input  logic                 pop,
	output logic                 empty,
	output tcdt_pkg::entry_t     rd_entry
);

	tcdt_pkg::entry_t                slots_q [tcdt_pkg::FIFO_DEPTH];
	logic [tcdt_pkg::FIFO_AW-1:0]    wptr_q, rptr_q;
	logic [tcdt_pkg::FIFO_AW:0]      count_q;
	logic                            do_pop;

	assign empty    = (count_q == '0);
	assign do_pop   = pop && !empty;
	assign rd_entry = slots_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr.push)
				wptr_q <= wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= rptr_q + 1'b1;
			if (wr.push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!wr.push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.push)
			slots_q[wptr_q] <= wr_entry;
	end

endmodule

/* hdl/tcdt_back.sv */
// tcdt_back: weight division, depth interpolation and z-buffer read-modify-write
// depends on tcdt_pkg; holds the z-buffer memory and the result register
module tcdt_back #(
	parameter int SCREEN_WIDTH  = tcdt_pkg::SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = tcdt_pkg::SCREEN_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  tcdt_pkg::entry_t  rd_entry,
	output logic              pop,
	output logic              clearing,
	output logic              result_valid,
	input  logic              result_ready,
	output tcdt_pkg::result_t result
);

	localparam int N  = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW = (N > 1) ? $clog2(N) : 1;
	localparam int DB = tcdt_pkg::DEPTH_BITS;

	tcdt_pkg::back_state_t          state_q, state_n;
	tcdt_pkg::entry_t               cur_q;
	logic [AW-1:0]                  addr_q, clr_q;
	logic [1:0]                     sel_q;
	logic [3:0]                     cnt_q;
	logic [tcdt_pkg::SW-1:0]        rem_q, rem_src, sum_q;
	logic [tcdt_pkg::SW:0]          trial;
	logic                           qbit;
	logic [tcdt_pkg::SW-1:0]        rem_n;
	logic [tcdt_pkg::WW-1:0]        quot_q, wa_q, wb_q, wc_q, w_sel;
	logic signed [23:0]             z_sel;
	logic signed [40:0]             prod;
	logic signed [tcdt_pkg::ACCW-1:0] acc_q, acc_rnd;
	logic signed [DB-1:0]           frag;
	logic signed [DB-1:0]           mem_q [N];
	logic signed [DB-1:0]           rdata_q;
	logic                           written_q;
	logic                           mem_we, mem_re;
	logic [AW-1:0]                  mem_wa;
	logic signed [DB-1:0]           mem_wd;
	logic                           out_free;

	assign out_free = !result_valid || result_ready;
	assign clearing = (state_q == tcdt_pkg::B_CLR);

	always_comb begin
		case (sel_q)
			2'd0:    rem_src = {2'b0, cur_q.m_bc};
			2'd1:    rem_src = {2'b0, cur_q.m_ca};
			default: rem_src = {2'b0, cur_q.m_ab};
		endcase
		if (cnt_q != 4'd0)
			rem_src = rem_q;
		trial = {rem_src, 1'b0};
		qbit  = (trial >= {1'b0, sum_q});
		rem_n = qbit ? tcdt_pkg::SW'(trial - {1'b0, sum_q}) : tcdt_pkg::SW'(trial);
		case (sel_q)
			2'd0: begin
				w_sel = wa_q;
				z_sel = cur_q.za;
			end
			2'd1: begin
				w_sel = wb_q;
				z_sel = cur_q.zb;
			end
			default: begin
				w_sel = wc_q;
				z_sel = cur_q.zc;
			end
		endcase
		prod    = $signed({1'b0, w_sel}) * z_sel;
		acc_rnd = acc_q + (acc_q[tcdt_pkg::ACCW-1] ? tcdt_pkg::ACCW'(65535) : '0);
		frag    = DB'(acc_rnd >>> 16);
	end

	always_comb begin
		state_n = state_q;
		pop     = 1'b0;
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		mem_wa  = clr_q;
		mem_wd  = {1'b1, {(DB-1){1'b0}}};
		case (state_q)
			tcdt_pkg::B_CLR: begin
				mem_we = 1'b1;
				if (32'(clr_q) == N - 1)
					state_n = tcdt_pkg::B_IDLE;
			end
			tcdt_pkg::B_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_n = rd_entry.covered ? tcdt_pkg::B_DIV : tcdt_pkg::B_OUT;
				end
			end
			tcdt_pkg::B_DIV: begin
				if (cnt_q == 4'd15 && sel_q == 2'd2)
					state_n = tcdt_pkg::B_MUL;
			end
			tcdt_pkg::B_MUL: begin
				if (sel_q == 2'd2)
					state_n = tcdt_pkg::B_RD;
			end
			tcdt_pkg::B_RD: begin
				mem_re  = 1'b1;
				state_n = cur_q.onscreen ? tcdt_pkg::B_CMP : tcdt_pkg::B_OUT;
			end
			tcdt_pkg::B_CMP: begin
				mem_wa  = addr_q;
				mem_wd  = frag;
				mem_we  = (frag > rdata_q);
				state_n = tcdt_pkg::B_OUT;
			end
			tcdt_pkg::B_OUT: begin
				if (out_free)
					state_n = tcdt_pkg::B_IDLE;
			end
			default: state_n = tcdt_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tcdt_pkg::B_CLR;
			clr_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == tcdt_pkg::B_CLR)
				clr_q <= clr_q + 1'b1;
			if (state_q == tcdt_pkg::B_OUT && out_free)
				result_valid <= 1'b1;
			else if (result_ready)
				result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tcdt_pkg::B_IDLE: begin
				cur_q     <= rd_entry;
				addr_q    <= AW'(32'(rd_entry.py) * SCREEN_WIDTH + 32'(rd_entry.px));
				sum_q     <= tcdt_pkg::SW'(rd_entry.m_ab) + tcdt_pkg::SW'(rd_entry.m_bc) +
					tcdt_pkg::SW'(rd_entry.m_ca);
				sel_q     <= 2'd0;
				cnt_q     <= 4'd0;
				wa_q      <= '0;
				wb_q      <= '0;
				wc_q      <= '0;
				acc_q     <= '0;
				written_q <= 1'b0;
			end
			tcdt_pkg::B_DIV: begin
				rem_q  <= rem_n;
				quot_q <= {quot_q[tcdt_pkg::WW-2:0], qbit};
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == 4'd15) begin
					case (sel_q)
						2'd0:    wa_q <= {quot_q[tcdt_pkg::WW-2:0], qbit};
						2'd1:    wb_q <= {quot_q[tcdt_pkg::WW-2:0], qbit};
						default: wc_q <= {quot_q[tcdt_pkg::WW-2:0], qbit};
					endcase
					sel_q <= (sel_q == 2'd2) ? 2'd0 : sel_q + 1'b1;
				end
			end
			tcdt_pkg::B_MUL: begin
				acc_q <= acc_q + tcdt_pkg::ACCW'(prod);
				sel_q <= sel_q + 1'b1;
			end
			tcdt_pkg::B_CMP: begin
				written_q <= (frag > rdata_q);
			end
			tcdt_pkg::B_OUT: begin
				if (out_free) begin
					result.covered       <= cur_q.covered;
					result.depth_written <= written_q;
					result.frag_depth    <= frag;
					result.weight_a      <= wa_q;
					result.weight_b      <= wb_q;
					result.weight_c      <= wc_q;
					result.out_pixel_x   <= cur_q.px;
					result.out_pixel_y   <= cur_q.py;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_wa] <= mem_wd;
		if (mem_re)
			rdata_q <= mem_q[addr_q];
	end

endmodule

/* hdl/triangle_coverage_depth_test_top.sv */
// triangle_coverage_depth_test_top: edge function coverage test with z-buffer update
// depends on tcdt_pkg, tcdt_front, tcdt_fifo, tcdt_back
//
//   channel   signals                            payload
//   item      item_valid / item_ready            tcdt_pkg::item_t
//   result    result_valid / result_ready        tcdt_pkg::result_t
//
// front end takes a transfer per cycle, unless held by a full queue or the z-buffer clear,
// into a two-stage edge pipeline and a four-entry queue; a covered fragment then passes
// the shared radix-2 divider (three 16-bit weights), the depth multiply-accumulate, then
// z-buffer read and write; an uncovered fragment goes straight to the result register
// after reset the z-buffer is cleared, one entry a cycle, all SCREEN_WIDTH*SCREEN_HEIGHT
// entries (307200 by default), and item_ready stays low until that is done
module triangle_coverage_depth_test_top #(
	parameter int SCREEN_WIDTH  = tcdt_pkg::SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = tcdt_pkg::SCREEN_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  tcdt_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output tcdt_pkg::result_t result
);

	tcdt_pkg::entry_t     f_entry, q_entry;
	tcdt_pkg::queue_ctl_t qctl;
	logic                 push, empty, pop, clearing;

	tcdt_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.clearing   (clearing),
		.queue_full (qctl.full),
		.push       (push),
		.entry      (f_entry)
	);

	assign qctl.push = push;

	tcdt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (qctl),
		.wr_entry (f_entry),
		.pop      (pop),
		.empty    (empty),
		.rd_entry (q_entry)
	);

	logic [tcdt_pkg::FIFO_AW:0] occ_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			occ_q <= '0;
		else if (push && !(pop && !empty))
			occ_q <= occ_q + 1'b1;
		else if (!push && pop && !empty)
			occ_q <= occ_q - 1'b1;
	end

	assign qctl.full = (32'(occ_q) == tcdt_pkg::FIFO_DEPTH);

	tcdt_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.rd_entry     (q_entry),
		.pop          (pop),
		.clearing     (clearing),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !item_ready)
		else $error("item taken during z-buffer clear");

	a_uncovered_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.covered |-> !result.depth_written &&
		result.weight_a == '0 && result.weight_b == '0 && result.weight_c == '0 &&
		result.frag_depth == '0)
		else $error("uncovered fragment carries data");

	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.covered |->
		(17'(result.weight_a) + 17'(result.weight_b) + 17'(result.weight_c)) <= 17'd65536)
		else $error("weights sum above one");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= tcdt_pkg::FIFO_DEPTH && !(empty && pop && $past(occ_q) == '0 && push))
		else $error("queue occupancy out of range");

endmodule
